[rtl/core/rat_pkg.sv]
// ----------------------------------------------------------------------------
// rat_pkg: shared types and constants of the row activation tracker
// Holds the command and result words, the state encodings and the fixed
// field widths used across the front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rat_pkg;

  // Fixed field widths.
  localparam int IN_ROW_W = 21;
  localparam int THR_W    = 16;
  localparam int LINE_W   = 34;
  localparam int STAMP_W  = 64;
  localparam int NUM_W    = 36;
  localparam int DEN_W    = 13;

  // Counter memory layout: base byte address and per-group stride (2^9 bytes).
  localparam logic [NUM_W-1:0] CTR_BASE     = 36'd16106127360;
  localparam int               STRIDE_SHIFT = 9;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0] GROUP_THR_RST = 16'd200;
  localparam logic [THR_W-1:0] ROW_THR_RST   = 16'd250;

  // What the back end must do with one activation.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_GROUP_INIT,
    CMD_ROW
  } cmd_kind_t;

  typedef struct packed {
    logic              request_valid;
    logic              request_write;
    logic [LINE_W-1:0] line_address;
    logic              mitigate;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_DECIDE,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_NONE,
    B_SETDIV,
    B_CNTRD,
    B_CNTCK,
    B_SCANRD,
    B_SCANCK,
    B_UPDATE,
    B_HITEMIT,
    B_LDIV1,
    B_EMIT1,
    B_LDIV2,
    B_EMIT2,
    B_WALK,
    B_GLINE,
    B_GEMIT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/row_activation_tracker_core.sv]
// ----------------------------------------------------------------------------
// row_activation_tracker_core: row-hammer activation tracker
// Group counters, per-row counters and an LRU row-count cache that issue
// counter-line reads and writebacks and flag rows needing mitigation.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Handshake
//  --------+-----------------------------------------+--------------------------
//  input   | in_row_address                          | in_push, in_full
//  result  | out_request_valid/_write, out_line_     | out_pop, out_empty
//          | address, out_mitigate, out_last         |
//  config  | cfg_index, cfg_data                     | cfg_we
//
// In the front end an activation passes the read, decide and push states, which
// read and update its group counter in a memory with a registered read port.
// In the back end an activation that only counts its group writes one word.
// One that reaches its group threshold scans its cache set one way at a time
// (a read state and a check state per way), writes one row counter per cycle
// for each of its 2^(ROW_BITS-GROUP_BITS) rows, and emits eight words.
// A row-path activation also reads its row counter, then writes one word on a
// cache hit, or a read request on a miss and a writeback when a valid victim is
// evicted. CACHE_SETS and LINE_BYTES are powers of two, so the set index and the
// counter line come from a mask and a shift. Every word waits while the
// output queue is full.
// After reset the back end clears the row counters and the cache, walking every
// address of a max(ROW_BITS, log2(CACHE_SETS*CACHE_WAYS))-bit counter;
// the front end clears the group counters. in_full holds the input off while
// the front end clears, then activations queue until the command queue fills.
// Configuration writes are taken at any time.
// A stalled result side only stops the back end; the front end keeps classifying
// into the two-entry command queue until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module row_activation_tracker_core #(
  parameter int GROUP_BITS = 14,
  parameter int ROW_BITS   = 21,
  parameter int CACHE_SETS = 512,
  parameter int CACHE_WAYS = 16,
  parameter int LINE_BYTES = 64,
  parameter int PAGE_BYTES = 8192
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration.
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [rat_pkg::THR_W-1:0]      cfg_data,
  // Activations.
  input  wire logic                           in_push,
  input  wire logic [rat_pkg::IN_ROW_W-1:0]   in_row_address,
  output logic                                in_full,
  // Results.
  input  wire logic                           out_pop,
  output logic                                out_empty,
  output logic                                out_request_valid,
  output logic                                out_request_write,
  output logic [rat_pkg::LINE_W-1:0]          out_line_address,
  output logic                                out_mitigate,
  output logic                                out_last
);

  localparam logic REG_GROUP_THRESHOLD = 1'b0;
  localparam logic REG_ROW_THRESHOLD   = 1'b1;
  localparam int   RES_W               = $bits(rat_pkg::result_t);

  logic [rat_pkg::THR_W-1:0] group_thr_r;
  logic [rat_pkg::THR_W-1:0] row_thr_r;

  // Front-to-back command queue.
  logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [ROW_BITS+1:0] cmd_wdata, cmd_rdata;

  // Back-to-port result queue.
  logic                res_push, res_full, res_pop, res_empty;
  rat_pkg::result_t    res_in, res_out;
  logic [RES_W-1:0]    res_rdata;

  // Configuration registers; the index decode covers both registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_thr_r <= rat_pkg::GROUP_THR_RST;
      row_thr_r   <= rat_pkg::ROW_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_THRESHOLD: group_thr_r <= cfg_data;
        REG_ROW_THRESHOLD:   row_thr_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rat_front #(
    .RB (ROW_BITS),
    .GB (GROUP_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .row       (ROW_BITS'(in_row_address)),
    .full      (in_full),
    .group_thr (group_thr_r),
    .q_push    (cmd_push),
    .q_data    (cmd_wdata),
    .q_full    (cmd_full)
  );

  rat_fifo #(
    .W     (ROW_BITS + 2),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  rat_back #(
    .RB         (ROW_BITS),
    .GB         (GROUP_BITS),
    .SETS       (CACHE_SETS),
    .WAYS       (CACHE_WAYS),
    .LINE_BYTES (LINE_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .group_thr (group_thr_r),
    .row_thr   (row_thr_r),
    .q_empty   (cmd_empty),
    .q_data    (cmd_rdata),
    .q_pop     (cmd_pop),
    .o_full    (res_full),
    .o_push    (res_push),
    .o_data    (res_in)
  );

  // The output queue decouples the result port from the back end, so a word
  // waiting to be popped blocks the back end only once the queue is full.
  rat_fifo #(
    .W     (RES_W),
    .DEPTH (4)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res_rdata),
    .empty (res_empty)
  );

  assign res_pop           = out_pop;
  assign res_out           = rat_pkg::result_t'(res_rdata);
  assign out_empty         = res_empty;
  assign out_request_valid = res_out.request_valid;
  assign out_request_write = res_out.request_write;
  assign out_line_address  = res_out.line_address;
  assign out_mitigate      = res_out.mitigate;
  assign out_last          = res_out.last;

  // The front end only hands over a command when the queue has room.
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  // The back end only writes a result word when the output queue has room.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // A word without a memory request always closes its activation.
  a_noreq_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_in.request_valid) |-> res_in.last)
    else $error("request-free result not marked last");

  // A write request never shows up without its valid flag.
  a_write_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_in.request_write) |-> res_in.request_valid)
    else $error("write flag on a result without a request");

endmodule

`default_nettype wire

[rtl/core/rat_fifo.sv]
// ----------------------------------------------------------------------------
// rat_fifo: small register queue
// First-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rat_div.sv]
// ----------------------------------------------------------------------------
// rat_div: divide by a fixed power of two
// Shifts a numerator right by a constant amount; the quotient is registered
// and valid in the cycle after start, when done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_div #(
  parameter int NW = 36,
  parameter int SH = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  output logic               done,
  output logic [NW-1:0]      quo
);

  logic [NW-1:0] quo_r;
  logic          done_r;

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    if (start) begin
      quo_r <= num >> SH;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rat_front.sv]
// ----------------------------------------------------------------------------
// rat_front: activation intake and group counting
// Counts activations per group and classifies each into a back-end command.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_front #(
  parameter int RB = 21,
  parameter int GB = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire logic [RB-1:0]           row,
  output logic                         full,
  input  wire logic [rat_pkg::THR_W-1:0] group_thr,
  output logic                         q_push,
  output logic [RB+1:0]                q_data,
  input  wire logic                    q_full
);

  localparam int NG = 1 << GB;

  logic [rat_pkg::THR_W-1:0] gmem [NG];
  logic [rat_pkg::THR_W-1:0] g_rd_r;
  logic [GB-1:0]             clr_r;
  logic                      clearing_r;
  rat_pkg::front_state_t     state_r, state_nxt;
  logic [RB-1:0]             row_r;
  rat_pkg::cmd_kind_t        kind_r;
  logic                      accept;
  logic                      g_we;
  logic [GB-1:0]             g_waddr;
  logic [rat_pkg::THR_W-1:0] g_wdata;
  logic [rat_pkg::THR_W-1:0] g_inc;

  assign accept = push && !full;
  assign g_inc  = g_rd_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rat_pkg::F_IDLE:   if (accept) state_nxt = rat_pkg::F_READ;
      rat_pkg::F_READ:   state_nxt = rat_pkg::F_DECIDE;
      rat_pkg::F_DECIDE: state_nxt = rat_pkg::F_PUSH;
      rat_pkg::F_PUSH:   if (!q_full) state_nxt = rat_pkg::F_IDLE;
      default:           state_nxt = rat_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full    = clearing_r || (state_r != rat_pkg::F_IDLE);
    q_push  = (state_r == rat_pkg::F_PUSH) && !q_full;
    q_data  = {kind_r, row_r};
    g_we    = 1'b0;
    g_waddr = row_r[GB-1:0];
    g_wdata = g_inc;
    if (clearing_r) begin
      g_we    = 1'b1;
      g_waddr = clr_r;
      g_wdata = '0;
    end else if (state_r == rat_pkg::F_DECIDE && g_rd_r < group_thr) begin
      g_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rat_pkg::F_IDLE;
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
    end
    if (accept) begin
      row_r <= row;
    end
    if (state_r == rat_pkg::F_DECIDE) begin
      if (g_rd_r < group_thr) begin
        kind_r <= (g_inc == group_thr) ? rat_pkg::CMD_GROUP_INIT : rat_pkg::CMD_NONE;
      end else begin
        kind_r <= rat_pkg::CMD_ROW;
      end
    end
    if (g_we) begin
      gmem[g_waddr] <= g_wdata;
    end
    g_rd_r <= gmem[row_r[GB-1:0]];
  end

endmodule

`default_nettype wire

[rtl/core/rat_back.sv]
// ----------------------------------------------------------------------------
// rat_back: row counters, row-count cache and request generation
// Executes one command at a time and writes its result words to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rat_back #(
  parameter int RB         = 21,
  parameter int GB         = 14,
  parameter int SETS       = 512,
  parameter int WAYS       = 16,
  parameter int LINE_BYTES = 64,
  parameter int PAGE_BYTES = 8192
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [rat_pkg::THR_W-1:0] group_thr,
  input  wire logic [rat_pkg::THR_W-1:0] row_thr,
  input  wire logic                      q_empty,
  input  wire logic [RB+1:0]             q_data,
  output logic                           q_pop,
  input  wire logic                      o_full,
  output logic                           o_push,
  output rat_pkg::result_t               o_data
);

  // SETS and LINE_BYTES are powers of two, so the set index is a mask of the
  // row and the counter line is a shift of its byte address.
  localparam int HW       = (RB > GB) ? RB - GB : 1;
  localparam int SLOTS    = SETS * WAYS;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW       = (RB > SLOT_W) ? RB : SLOT_W;
  localparam int CE_W     = 1 + RB + rat_pkg::STAMP_W;
  localparam int PPL      = PAGE_BYTES / LINE_BYTES;
  localparam int PPL_W    = $clog2(PPL) + 1;
  localparam int NR       = 1 << RB;
  localparam int LINE_SH  = $clog2(LINE_BYTES);
  localparam logic [RB-1:0] SET_MASK = RB'(SETS - 1);

  // Storage.
  logic [rat_pkg::THR_W-1:0] rmem [NR];
  logic [CE_W-1:0]           cmem [SLOTS];
  logic [rat_pkg::THR_W-1:0] r_rd_r;
  logic [CE_W-1:0]           c_rd_r;

  logic                      clearing_r;
  logic [CW-1:0]             clr_r;
  logic [rat_pkg::STAMP_W-1:0] stamp_r;
  rat_pkg::back_state_t      state_r, state_nxt;

  logic [RB-1:0]             row_r;
  rat_pkg::cmd_kind_t        kind_r;
  rat_pkg::cmd_kind_t        q_kind;
  logic [RB-1:0]             q_row;
  logic                      mit_r;
  logic [rat_pkg::THR_W-1:0] cnt_r;
  logic [SLOT_W:0]           base_r;
  logic [WAY_W-1:0]          way_r;
  logic                      hit_r, inv_r, had_r;
  logic [WAY_W-1:0]          hit_way_r, inv_way_r, lru_way_r;
  logic [RB-1:0]             lru_tag_r;
  logic [rat_pkg::STAMP_W-1:0] min_r;
  logic [rat_pkg::LINE_W-1:0] line_r;
  logic [HW-1:0]             walk_r;
  logic [2:0]                emit_r;

  logic                      c_valid;
  logic [RB-1:0]             c_tag;
  logic [rat_pkg::STAMP_W-1:0] c_stamp;
  logic                      last_way;
  logic [WAY_W-1:0]          tgt_way;
  logic [RB+PPL_W-1:0]       gl_prod;

  logic                      div_start, div_done;
  logic [rat_pkg::NUM_W-1:0] div_num, div_quo;

  logic                      r_we;
  logic [RB-1:0]             r_waddr;
  logic [rat_pkg::THR_W-1:0] r_wdata;
  logic                      c_we;
  logic [SLOT_W-1:0]         c_waddr, c_raddr;
  logic [CE_W-1:0]           c_wdata;

  assign q_kind   = rat_pkg::cmd_kind_t'(q_data[RB+1:RB]);
  assign q_row    = q_data[RB-1:0];
  assign c_valid  = c_rd_r[CE_W-1];
  assign c_tag    = c_rd_r[CE_W-2 -: RB];
  assign c_stamp  = c_rd_r[rat_pkg::STAMP_W-1:0];
  assign last_way = (way_r == WAY_W'(WAYS - 1));
  assign tgt_way  = hit_r ? hit_way_r : (inv_r ? inv_way_r : lru_way_r);
  assign c_raddr  = SLOT_W'(base_r + (SLOT_W+1)'(way_r));
  assign gl_prod  = (RB+PPL_W)'(row_r) * (RB+PPL_W)'(PPL);

  // Counter-line numerator of a row: base + group * stride + upper row bits.
  function automatic logic [rat_pkg::NUM_W-1:0] line_num(input logic [RB-1:0] r);
    line_num = rat_pkg::CTR_BASE
             + (rat_pkg::NUM_W'(r[GB-1:0]) << rat_pkg::STRIDE_SHIFT)
             + rat_pkg::NUM_W'(r >> GB);
  endfunction

  rat_div #(
    .NW (rat_pkg::NUM_W),
    .SH (LINE_SH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rat_pkg::B_IDLE: begin
        if (!clearing_r && !q_empty) begin
          state_nxt = (q_kind == rat_pkg::CMD_NONE) ? rat_pkg::B_NONE : rat_pkg::B_SETDIV;
        end
      end
      rat_pkg::B_NONE:    if (!o_full) state_nxt = rat_pkg::B_IDLE;
      rat_pkg::B_SETDIV: begin
        state_nxt = (kind_r == rat_pkg::CMD_ROW) ? rat_pkg::B_CNTRD : rat_pkg::B_SCANRD;
      end
      rat_pkg::B_CNTRD:   state_nxt = rat_pkg::B_CNTCK;
      rat_pkg::B_CNTCK:   state_nxt = rat_pkg::B_SCANRD;
      rat_pkg::B_SCANRD:  state_nxt = rat_pkg::B_SCANCK;
      rat_pkg::B_SCANCK:  state_nxt = last_way ? rat_pkg::B_UPDATE : rat_pkg::B_SCANRD;
      rat_pkg::B_UPDATE: begin
        if (kind_r != rat_pkg::CMD_ROW) begin
          state_nxt = rat_pkg::B_WALK;
        end else if (hit_r) begin
          state_nxt = rat_pkg::B_HITEMIT;
        end else begin
          state_nxt = rat_pkg::B_LDIV1;
        end
      end
      rat_pkg::B_HITEMIT: if (!o_full) state_nxt = rat_pkg::B_IDLE;
      rat_pkg::B_LDIV1:   if (div_done) state_nxt = rat_pkg::B_EMIT1;
      rat_pkg::B_EMIT1: begin
        if (!o_full) begin
          state_nxt = had_r ? rat_pkg::B_LDIV2 : rat_pkg::B_IDLE;
        end
      end
      rat_pkg::B_LDIV2:   if (div_done) state_nxt = rat_pkg::B_EMIT2;
      rat_pkg::B_EMIT2:   if (!o_full) state_nxt = rat_pkg::B_IDLE;
      rat_pkg::B_WALK:    if (walk_r == '1) state_nxt = rat_pkg::B_GLINE;
      rat_pkg::B_GLINE:   state_nxt = rat_pkg::B_GEMIT;
      rat_pkg::B_GEMIT:   if (!o_full && emit_r == 3'd7) state_nxt = rat_pkg::B_IDLE;
      default:            state_nxt = rat_pkg::B_IDLE;
    endcase
  end

  // Outputs, memory ports and divider control.
  always_comb begin
    q_pop     = 1'b0;
    o_push    = 1'b0;
    o_data    = '0;
    div_start = 1'b0;
    div_num   = line_num(row_r);
    r_we      = 1'b0;
    r_waddr   = row_r;
    r_wdata   = mit_r ? rat_pkg::THR_W'(1) : cnt_r + 1'b1;
    c_we      = 1'b0;
    c_waddr   = SLOT_W'(base_r + (SLOT_W+1)'(tgt_way));
    c_wdata   = {1'b1, row_r, stamp_r};
    unique case (state_r)
      rat_pkg::B_IDLE: begin
        q_pop = !clearing_r && !q_empty;
      end
      rat_pkg::B_NONE, rat_pkg::B_HITEMIT: begin
        o_push          = !o_full;
        o_data.mitigate = mit_r;
        o_data.last     = 1'b1;
      end
      rat_pkg::B_UPDATE: begin
        c_we = 1'b1;
        if (kind_r == rat_pkg::CMD_ROW) begin
          r_we      = 1'b1;
          div_start = !hit_r;
        end
      end
      rat_pkg::B_EMIT1: begin
        o_push               = !o_full;
        o_data.request_valid = 1'b1;
        o_data.line_address  = line_r;
        o_data.mitigate      = mit_r;
        o_data.last          = !had_r;
        if (!o_full && had_r) begin
          div_start = 1'b1;
          div_num   = line_num(lru_tag_r);
        end
      end
      rat_pkg::B_EMIT2: begin
        o_push               = !o_full;
        o_data.request_valid = 1'b1;
        o_data.request_write = 1'b1;
        o_data.line_address  = line_r;
        o_data.mitigate      = mit_r;
        o_data.last          = 1'b1;
      end
      rat_pkg::B_WALK: begin
        r_we    = 1'b1;
        r_waddr = RB'({walk_r, row_r[GB-1:0]});
        r_wdata = group_thr;
      end
      rat_pkg::B_GEMIT: begin
        o_push               = !o_full;
        o_data.request_valid = 1'b1;
        o_data.request_write = emit_r[2];
        o_data.line_address  = line_r;
        o_data.last          = (emit_r == 3'd7);
      end
      default: begin
      end
    endcase
    if (clearing_r) begin
      r_we    = 1'b1;
      r_waddr = clr_r[RB-1:0];
      r_wdata = '0;
      c_we    = ((SLOT_W+1)'(clr_r[SLOT_W-1:0]) < (SLOT_W+1)'(SLOTS));
      c_waddr = clr_r[SLOT_W-1:0];
      c_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rat_pkg::B_IDLE;
      clearing_r <= 1'b1;
      clr_r      <= '0;
      stamp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      if (state_r == rat_pkg::B_CNTCK) begin
        stamp_r <= stamp_r + 1'b1;
      end
    end

    case (state_r)
      rat_pkg::B_IDLE: begin
        if (q_pop) begin
          kind_r <= q_kind;
          row_r  <= q_row;
          mit_r  <= 1'b0;
        end
      end
      rat_pkg::B_SETDIV: begin
        base_r <= (SLOT_W+1)'(row_r & SET_MASK) * (SLOT_W+1)'(WAYS);
        way_r  <= '0;
        hit_r  <= 1'b0;
        inv_r  <= 1'b0;
      end
      rat_pkg::B_CNTCK: begin
        cnt_r <= r_rd_r;
        mit_r <= (r_rd_r == row_thr - 1'b1);
      end
      rat_pkg::B_SCANCK: begin
        if (c_valid && c_tag == row_r && !hit_r) begin
          hit_r     <= 1'b1;
          hit_way_r <= way_r;
        end
        if (!c_valid && !inv_r) begin
          inv_r     <= 1'b1;
          inv_way_r <= way_r;
        end
        if (way_r == '0 || c_stamp < min_r) begin
          min_r     <= c_stamp;
          lru_way_r <= way_r;
          lru_tag_r <= c_tag;
        end
        if (!last_way) begin
          way_r <= way_r + 1'b1;
        end
      end
      rat_pkg::B_UPDATE: begin
        had_r  <= !hit_r && !inv_r;
        walk_r <= '0;
      end
      rat_pkg::B_LDIV1, rat_pkg::B_LDIV2: begin
        if (div_done) begin
          line_r <= rat_pkg::LINE_W'(div_quo);
        end
      end
      rat_pkg::B_WALK: begin
        walk_r <= walk_r + 1'b1;
      end
      rat_pkg::B_GLINE: begin
        line_r <= rat_pkg::LINE_W'(gl_prod);
        emit_r <= '0;
      end
      rat_pkg::B_GEMIT: begin
        if (!o_full) begin
          emit_r <= emit_r + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    r_rd_r <= rmem[row_r];
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    c_rd_r <= cmem[c_raddr];
  end

endmodule

`default_nettype wire

[tb/row_activation_tracker_core_tb.sv]
// ----------------------------------------------------------------------------
// row_activation_tracker_core_tb: self-checking bench of the activation tracker
// Sends row activations through the push/full port, predicts every result word
// with a local model of the group counters, row counters and LRU counter cache,
// and checks each popped word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_activation_tracker_core_tb;

  localparam int CLK_PERIOD = 8;
  // The back end clears its row counters after reset, so the watchdog must
  // outlast that clearing pass by a comfortable margin.
  localparam int STALL_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int NUM_SLOTS = 512 * 16;
  localparam logic CFG_GROUP_THR = 1'b0;
  localparam logic CFG_ROW_THR   = 1'b1;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [rat_pkg::THR_W-1:0]     cfg_data;
  logic                          in_push;
  logic [rat_pkg::IN_ROW_W-1:0]  in_row_address;
  logic                          in_full;
  logic                          out_pop;
  logic                          out_empty;
  logic                          out_request_valid;
  logic                          out_request_write;
  logic [rat_pkg::LINE_W-1:0]    out_line_address;
  logic                          out_mitigate;
  logic                          out_last;

  row_activation_tracker_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_row_address    (in_row_address),
    .in_full           (in_full),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_request_valid (out_request_valid),
    .out_request_write (out_request_write),
    .out_line_address  (out_line_address),
    .out_mitigate      (out_mitigate),
    .out_last          (out_last)
  );

  // Local copy of the tracker state, mirrored from what was sent and written.
  logic [rat_pkg::THR_W-1:0]    group_cnt [16384];
  logic [rat_pkg::THR_W-1:0]    row_cnt [2097152];
  bit                           slot_valid [NUM_SLOTS];
  logic [rat_pkg::IN_ROW_W-1:0] slot_tag [NUM_SLOTS];
  longint unsigned              slot_stamp [NUM_SLOTS];
  longint unsigned              lookup_stamp;
  logic [rat_pkg::THR_W-1:0]    group_thr;
  logic [rat_pkg::THR_W-1:0]    row_thr;

  // Words still owed by the block, oldest first.
  rat_pkg::result_t pending_words[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  errors;
  int  rows_sent;
  int  words_seen;
  int  mitigations_seen;
  int  writebacks_seen;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [rat_pkg::LINE_W-1:0] counter_line_of(
      logic [rat_pkg::IN_ROW_W-1:0] row);
    longint unsigned addr;
    addr = longint'(rat_pkg::CTR_BASE) + longint'(row[13:0]) * 512 + longint'(row[20:14]);
    return rat_pkg::LINE_W'(addr / 64);
  endfunction

  function automatic void owe_word(bit req, bit wr, logic [rat_pkg::LINE_W-1:0] line,
                                   bit mit);
    rat_pkg::result_t w;
    w.request_valid = req;
    w.request_write = wr;
    w.line_address  = line;
    w.mitigate      = mit;
    w.last          = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic int lookup_way(logic [rat_pkg::IN_ROW_W-1:0] row);
    int base;
    base = int'(row[8:0]) * 16;
    for (int w = 0; w < 16; w++)
      if (slot_valid[base + w] && slot_tag[base + w] == row) return w;
    return -1;
  endfunction

  // Places a row that is not cached; returns 1 and the victim tag when a valid
  // way was evicted. An empty way wins first, else the oldest stamp (lowest way
  // on a tie).
  function automatic bit place_row(logic [rat_pkg::IN_ROW_W-1:0] row,
                                   output logic [rat_pkg::IN_ROW_W-1:0] victim);
    int  base;
    int  pick;
    bit  found;
    base   = int'(row[8:0]) * 16;
    pick   = base;
    found  = 1'b0;
    victim = '0;
    for (int w = 0; w < 16 && !found; w++)
      if (!slot_valid[base + w]) begin
        pick  = base + w;
        found = 1'b1;
      end
    if (!found) begin
      for (int w = 1; w < 16; w++)
        if (slot_stamp[base + w] < slot_stamp[pick]) pick = base + w;
      victim = slot_tag[pick];
    end
    slot_valid[pick] = 1'b1;
    slot_tag[pick]   = row;
    slot_stamp[pick] = lookup_stamp;
    return !found;
  endfunction

  function automatic void predict_activation(logic [rat_pkg::IN_ROW_W-1:0] row);
    logic [13:0]                  grp;
    logic [rat_pkg::LINE_W-1:0]   line;
    logic [rat_pkg::IN_ROW_W-1:0] victim;
    logic [rat_pkg::THR_W-1:0]    trig;
    int                           way;
    int                           owed_at_start;
    bit                           mit;
    grp           = row[13:0];
    owed_at_start = pending_words.size();
    mit           = 1'b0;
    if (group_cnt[grp] < group_thr) begin
      group_cnt[grp] = group_cnt[grp] + 1'b1;
      if (group_cnt[grp] == group_thr) begin
        // Group just reached its threshold: seed all its rows, cache the row,
        // then four reads and four writebacks of the row's own line.
        line = rat_pkg::LINE_W'(row) * 128;
        for (int h = 0; h < 128; h++) row_cnt[{h[6:0], grp}] = group_thr;
        way = lookup_way(row);
        if (way >= 0) slot_stamp[int'(row[8:0]) * 16 + way] = lookup_stamp;
        else void'(place_row(row, victim));
        for (int i = 0; i < 4; i++) owe_word(1'b1, 1'b0, line, 1'b0);
        for (int i = 0; i < 4; i++) owe_word(1'b1, 1'b1, line, 1'b0);
      end
    end else begin
      trig = row_thr - 1'b1;
      if (row_cnt[row] == trig) begin
        mit          = 1'b1;
        row_cnt[row] = '0;
      end
      lookup_stamp++;
      way = lookup_way(row);
      if (way >= 0) begin
        slot_stamp[int'(row[8:0]) * 16 + way] = lookup_stamp;
      end else begin
        owe_word(1'b1, 1'b0, counter_line_of(row), mit);
        if (place_row(row, victim)) owe_word(1'b1, 1'b1, counter_line_of(victim), mit);
      end
      row_cnt[row] = row_cnt[row] + 1'b1;
    end
    if (pending_words.size() == owed_at_start) owe_word(1'b0, 1'b0, '0, mit);
    pending_words[pending_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_row(logic [rat_pkg::IN_ROW_W-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_row_address <= row;
    do @(posedge clk); while (in_full);
    predict_activation(row);
    rows_sent++;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [rat_pkg::THR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_GROUP_THR) group_thr = value;
    else row_thr = value;
  endtask

  task automatic set_thresholds(logic [rat_pkg::THR_W-1:0] gthr,
                                logic [rat_pkg::THR_W-1:0] rthr);
    write_reg(CFG_GROUP_THR, gthr);
    write_reg(CFG_ROW_THR, rthr);
  endtask

  // Mostly rows that crowd one of two cache sets, so that groups fill, rows get
  // hammered and ways are evicted; the rest are rows from anywhere.
  function automatic logic [rat_pkg::IN_ROW_W-1:0] hot_row();
    logic [rat_pkg::IN_ROW_W-1:0] r;
    if ($urandom_range(99) < 20) return rat_pkg::IN_ROW_W'($urandom_range(2097151));
    r[8:0]   = ($urandom_range(1)) ? 9'd37 : 9'd300;
    r[13:9]  = 5'($urandom_range(7));
    r[20:14] = 7'($urandom_range(3));
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    errors++;
  endtask

  // Samples right after the edge, before the block's own updates land, so the
  // values seen are the ones the edge accepted.
  always @(posedge clk) begin
    rat_pkg::result_t want;
    if (rst_n && in_push && !in_full) quiet_cycles = 0;
    if (rst_n && out_pop && !out_empty) begin
      quiet_cycles = 0;
      words_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual line 0x%0h",
                 $time, out_line_address);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_request_valid !== want.request_valid)
          report_field("request_valid", want.request_valid, out_request_valid);
        if (out_request_write !== want.request_write)
          report_field("request_write", want.request_write, out_request_write);
        if (out_line_address !== want.line_address)
          report_field("line_address", want.line_address, out_line_address);
        if (out_mitigate !== want.mitigate)
          report_field("mitigate", want.mitigate, out_mitigate);
        if (out_last !== want.last)
          report_field("last", want.last, out_last);
        if (want.mitigate && want.last) mitigations_seen++;
        if (want.request_valid && want.request_write) writebacks_seen++;
      end
    end
    quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d words owed", $time, pending_words.size());
      $display("Mismatches found");
      $finish;
    end
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- tests

  // Reset thresholds: no group can fill in a few activations, so each word is
  // a lone no-request word. Covers the address extremes and single bits.
  task automatic test_reset_thresholds();
    send_row('0);
    send_row('1);
    for (int b = 0; b < rat_pkg::IN_ROW_W; b += 5) send_row(rat_pkg::IN_ROW_W'(1) << b);
    send_row(21'h155555);
    wait_idle();
  endtask

  // Group threshold of one: the first touch of a group seeds it; the next touch
  // of the same row hits the cache and, with row threshold two, mitigates.
  // Eighteen groups crowding one set evict silently on group fill, then
  // sibling rows miss and write back the LRU victim.
  task automatic test_group_fill_and_eviction();
    set_thresholds(16'd1, 16'd2);
    send_row(21'd5);
    send_row(21'd5);
    send_row(21'd5 + 21'd16384);
    send_row('1);
    send_row('1);
    for (int k = 0; k < 18; k++) send_row(21'(7 + k * 512));
    for (int k = 0; k < 4; k++) send_row(21'(7 + k * 512 + 16384));
    wait_idle();
  endtask

  // Both thresholds at their maximum: groups count but never fill.
  task automatic test_max_thresholds();
    set_thresholds(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_row(hot_row());
    wait_idle();
  endtask

  task automatic test_random_traffic(int items, int send_pct, int recv_pct,
                                     logic [rat_pkg::THR_W-1:0] gthr,
                                     logic [rat_pkg::THR_W-1:0] rthr,
                                     bit drain_midway);
    set_thresholds(gthr, rthr);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < items; i++) begin
      // Hold off once so the block runs completely dry mid-stream.
      if (drain_midway && i == items / 2) begin
        in_push <= 1'b0;
        wait (pending_words.size() == 0);
        @(posedge clk);
      end
      send_row(hot_row());
    end
    wait_idle();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_GROUP_THR;
    cfg_data         = '0;
    in_push          = 1'b0;
    in_row_address   = '0;
    out_pop          = 1'b0;
    send_idle_pct    = 27;
    recv_idle_pct    = 81;
    errors           = 0;
    rows_sent        = 0;
    words_seen       = 0;
    mitigations_seen = 0;
    writebacks_seen  = 0;
    quiet_cycles     = 0;
    lookup_stamp     = 0;
    group_thr        = rat_pkg::GROUP_THR_RST;
    row_thr          = rat_pkg::ROW_THR_RST;
    foreach (group_cnt[i]) group_cnt[i] = '0;
    foreach (row_cnt[i]) row_cnt[i] = '0;
    foreach (slot_valid[i]) begin
      slot_valid[i] = 1'b0;
      slot_tag[i]   = '0;
      slot_stamp[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_thresholds();
    test_group_fill_and_eviction();
    test_max_thresholds();
    test_random_traffic(60, 27, 81, 16'd2, 16'd3, 1'b1);
    test_random_traffic(60, 81, 27, 16'd3, 16'd2, 1'b0);
    test_random_traffic(60, 0, 0, 16'd1, 16'd4, 1'b0);

    in_push <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d activations and checked %0d words (%0d writebacks, %0d mitigations)",
             rows_sent, words_seen, writebacks_seen, mitigations_seen);
    $display("across reset, minimum, maximum and three random threshold settings.");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[row_activation_tracker_core.f]
rtl/core/rat_pkg.sv
rtl/core/rat_fifo.sv
rtl/core/rat_div.sv
rtl/core/rat_front.sv
rtl/core/rat_back.sv
rtl/core/row_activation_tracker_core.sv
tb/row_activation_tracker_core_tb.sv
